[rtl/core/tbms_pkg.sv]
// ----------------------------------------------------------------------------
// tbms_pkg
// Types and constants for the two-button menu selector.
// ----------------------------------------------------------------------------
package tbms_pkg;

  localparam logic [7:0]  ITEM_COUNT_RST  = 8'd1;
  localparam logic [15:0] HOLD_TIME_RST   = 16'd400;
  localparam logic [15:0] SETTLE_TIME_RST = 16'd220;
  localparam logic [7:0]  NO_CHOICE       = 8'hFF;

  localparam logic [1:0] REG_ITEM_COUNT  = 2'd0;
  localparam logic [1:0] REG_HOLD_TIME   = 2'd1;
  localparam logic [1:0] REG_SETTLE_TIME = 2'd2;

  localparam logic CMD_OPEN   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic        next_down;
    logic        prev_down;
    logic [7:0]  start_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] selected_index;
    logic       menu_open;
    logic       menu_closing;
    logic       chosen_pulse;
    logic       cancel_pulse;
    logic       moved_pulse;
    logic [7:0] result_index;
    logic       result_ready;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  item_count;
    logic [15:0] hold_time_ms;
    logic [15:0] settle_time_ms;
  } cfg_t;

endpackage

[rtl/core/tbms_ifs.sv]
// ----------------------------------------------------------------------------
// tbms channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface tbms_in_if;
  logic               valid;
  logic               ready;
  tbms_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbms_out_if;
  logic                valid;
  logic                ready;
  tbms_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/two_button_menu_selector.sv]
// ----------------------------------------------------------------------------
// two_button_menu_selector
// Menu selection driven by next/prev button samples and open commands.
//
// in_ch carries one word per open command or button sample; out_ch returns
// exactly one result word for every input word, in order. A word taken is
// registered, processed by the core once the output register can advance,
// and its result is registered from there into the output register.
// One word per cycle is sustained while out_ch does not stall; the limit
// is the menu state update, which the next word reads straight away.
// cfg_we/cfg_index/cfg_wdata write item_count, hold_time_ms and
// settle_time_ms; write only while the block is idle.
// Reset (rst_n low, synchronous) closes the menu, forgets the remembered
// choice and restores the register defaults (1, 400, 220).
// A stalled out_ch holds its word; in_ch keeps accepting until the input
// register is also full, then drops ready until the result is taken.
// ----------------------------------------------------------------------------
module two_button_menu_selector (
  input  logic        clk,
  input  logic        rst_n,
  tbms_in_if.sink     in_ch,
  tbms_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  tbms_pkg::cfg_t      cfg_r;
  logic                in_valid_r;
  tbms_pkg::in_word_t  in_word_r;
  logic                out_valid_r;
  tbms_pkg::out_word_t out_word_r;
  tbms_pkg::out_word_t res;
  logic                advance;
  logic                fire;

  assign advance      = !out_valid_r || out_ch.ready;
  assign fire         = in_valid_r && advance;
  assign in_ch.ready  = advance || !in_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.item_count     <= tbms_pkg::ITEM_COUNT_RST;
      cfg_r.hold_time_ms   <= tbms_pkg::HOLD_TIME_RST;
      cfg_r.settle_time_ms <= tbms_pkg::SETTLE_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tbms_pkg::REG_ITEM_COUNT:  cfg_r.item_count     <= cfg_wdata[7:0];
        tbms_pkg::REG_HOLD_TIME:   cfg_r.hold_time_ms   <= cfg_wdata;
        tbms_pkg::REG_SETTLE_TIME: cfg_r.settle_time_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_word_r <= in_ch.data;
    end
    if (fire) begin
      out_word_r <= res;
    end
  end

  tbms_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .word  (in_word_r),
    .res   (res)
  );

endmodule

[rtl/core/tbms_core.sv]
// ----------------------------------------------------------------------------
// tbms_core
// Menu state and the single-pass update for one input word.
// ----------------------------------------------------------------------------
module tbms_core (
  input  logic                clk,
  input  logic                rst_n,
  input  tbms_pkg::cfg_t      cfg,
  input  logic                fire,
  input  tbms_pkg::in_word_t  word,
  output tbms_pkg::out_word_t res
);

  logic        active_r, active_nxt;
  logic        closing_r, closing_nxt;
  logic        armed_r, armed_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [7:0]  cur_r, cur_nxt;
  logic        last_next_r, last_next_nxt;
  logic        last_prev_r, last_prev_nxt;
  logic [31:0] nps_r, nps_nxt;
  logic [31:0] pps_r, pps_nxt;
  logic        nld_r, nld_nxt;
  logic        pld_r, pld_nxt;
  logic [7:0]  mem_idx_r, mem_idx_nxt;
  logic        mem_valid_r, mem_valid_nxt;
  logic [7:0]  held_result_r, held_result_nxt;
  logic        held_ready_r, held_ready_nxt;

  logic [15:0] settle;
  logic [31:0] phase_el;
  logic [31:0] next_el;
  logic [31:0] prev_el;
  logic [7:0]  cnt;
  logic [7:0]  checked;
  logic [7:0]  start;
  logic        chosen, cancel, moved, done;

  always_comb begin
    active_nxt      = active_r;
    closing_nxt     = closing_r;
    armed_nxt       = armed_r;
    phase_nxt       = phase_r;
    cur_nxt         = cur_r;
    last_next_nxt   = last_next_r;
    last_prev_nxt   = last_prev_r;
    nps_nxt         = nps_r;
    pps_nxt         = pps_r;
    nld_nxt         = nld_r;
    pld_nxt         = pld_r;
    mem_idx_nxt     = mem_idx_r;
    mem_valid_nxt   = mem_valid_r;
    held_result_nxt = held_result_r;
    held_ready_nxt  = held_ready_r;
    chosen          = 1'b0;
    cancel          = 1'b0;
    moved           = 1'b0;
    done            = 1'b0;
    cnt             = cfg.item_count;
    settle          = (cfg.settle_time_ms == 16'd0) ? 16'd1 : cfg.settle_time_ms;
    phase_el        = word.now_ms - phase_r;
    next_el         = word.now_ms - nps_r;
    prev_el         = word.now_ms - pps_r;
    checked         = tbms_pkg::NO_CHOICE;
    start           = word.start_index;

    if (fire) begin
      // end the close phase
      if (active_r && closing_r && phase_el >= {16'd0, settle}) begin
        active_nxt  = 1'b0;
        closing_nxt = 1'b0;
      end
      if (word.command == tbms_pkg::CMD_OPEN) begin
        if (cnt != 8'd0 && !(active_nxt && !closing_nxt)) begin
          if (mem_valid_r && mem_idx_r < cnt) begin
            checked = mem_idx_r;
          end
          if (word.start_index == tbms_pkg::NO_CHOICE) begin
            start = (checked < cnt) ? checked : 8'd0;
          end else if (word.start_index >= cnt) begin
            start = 8'd0;
          end
          cur_nxt         = start;
          nps_nxt         = 32'd0;
          pps_nxt         = 32'd0;
          nld_nxt         = 1'b0;
          pld_nxt         = 1'b0;
          last_next_nxt   = 1'b0;
          last_prev_nxt   = 1'b0;
          held_result_nxt = 8'd0;
          held_ready_nxt  = 1'b0;
          armed_nxt       = 1'b0;
          phase_nxt       = word.now_ms;
          active_nxt      = 1'b1;
          closing_nxt     = 1'b0;
        end
      end else if (active_nxt && !closing_nxt && cnt != 8'd0) begin
        if (!armed_r) begin
          last_next_nxt = word.next_down;
          last_prev_nxt = word.prev_down;
          if (phase_el >= {16'd0, settle} && !word.next_down && !word.prev_down) begin
            armed_nxt     = 1'b1;
            last_next_nxt = 1'b0;
            last_prev_nxt = 1'b0;
          end
        end else begin
          if (word.next_down) begin
            if (!last_next_r) begin
              nps_nxt = word.now_ms;
              nld_nxt = 1'b0;
            end else if (!nld_r && nps_r != 32'd0 && next_el >= {16'd0, cfg.hold_time_ms}) begin
              mem_idx_nxt     = cur_r;
              mem_valid_nxt   = 1'b1;
              held_result_nxt = cur_r;
              held_ready_nxt  = 1'b1;
              closing_nxt     = 1'b1;
              phase_nxt       = word.now_ms;
              nld_nxt         = 1'b1;
              chosen          = 1'b1;
              done            = 1'b1;
            end
          end else begin
            if (last_next_r && !nld_r) begin
              cur_nxt = (({1'b0, cur_r} + 9'd1) < {1'b0, cnt}) ? cur_r + 8'd1 : 8'd0;
              moved   = 1'b1;
            end
            nps_nxt = 32'd0;
            nld_nxt = 1'b0;
          end
          if (!done) begin
            if (word.prev_down) begin
              if (!last_prev_r) begin
                pps_nxt = word.now_ms;
                pld_nxt = 1'b0;
              end else if (!pld_r && pps_r != 32'd0 &&
                           prev_el >= {16'd0, cfg.hold_time_ms}) begin
                closing_nxt = 1'b1;
                phase_nxt   = word.now_ms;
                pld_nxt     = 1'b1;
                cancel      = 1'b1;
                done        = 1'b1;
              end
            end else begin
              if (last_prev_r && !pld_r) begin
                cur_nxt = (cur_nxt != 8'd0) ? cur_nxt - 8'd1 : cnt - 8'd1;
                moved   = 1'b1;
              end
              pps_nxt = 32'd0;
              pld_nxt = 1'b0;
            end
          end
          if (!done) begin
            last_next_nxt = word.next_down;
            last_prev_nxt = word.prev_down;
          end
        end
      end
    end
  end

  always_comb begin
    res.selected_index = cur_nxt;
    res.menu_open      = active_nxt;
    res.menu_closing   = closing_nxt;
    res.chosen_pulse   = chosen;
    res.cancel_pulse   = cancel;
    res.moved_pulse    = moved;
    res.result_index   = held_result_nxt;
    res.result_ready   = held_ready_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r      <= 1'b0;
      closing_r     <= 1'b0;
      armed_r       <= 1'b0;
      phase_r       <= 32'd0;
      cur_r         <= 8'd0;
      last_next_r   <= 1'b0;
      last_prev_r   <= 1'b0;
      nps_r         <= 32'd0;
      pps_r         <= 32'd0;
      nld_r         <= 1'b0;
      pld_r         <= 1'b0;
      mem_idx_r     <= 8'd0;
      mem_valid_r   <= 1'b0;
      held_result_r <= 8'd0;
      held_ready_r  <= 1'b0;
    end else begin
      active_r      <= active_nxt;
      closing_r     <= closing_nxt;
      armed_r       <= armed_nxt;
      phase_r       <= phase_nxt;
      cur_r         <= cur_nxt;
      last_next_r   <= last_next_nxt;
      last_prev_r   <= last_prev_nxt;
      nps_r         <= nps_nxt;
      pps_r         <= pps_nxt;
      nld_r         <= nld_nxt;
      pld_r         <= pld_nxt;
      mem_idx_r     <= mem_idx_nxt;
      mem_valid_r   <= mem_valid_nxt;
      held_result_r <= held_result_nxt;
      held_ready_r  <= held_ready_nxt;
    end
  end

endmodule

[sim/two_button_menu_selector_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_button_menu_selector_tb
// Self-checking bench for the two-button menu selector. Open commands and
// button samples go in on the input channel under random gaps, and result
// words come back under random back-pressure, including one long hold-off.
// A scoreboard keeps its own copy of the menu state and configuration and
// checks every result word, field by field and in order. A short directed
// run comes first. Randomised menu sessions follow under several register
// settings, including the extremes of every register.
// ----------------------------------------------------------------------------
module two_button_menu_selector_tb;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int          HOLD_OFF_CYCLES = 64;

  class menu_tracker;
    logic [7:0]  item_count;
    logic [15:0] hold_ms;
    logic [15:0] settle_ms;
    bit          active, closing, armed;
    bit [31:0]   phase_start;
    bit [7:0]    cur_idx, checked_idx;
    bit          last_next, last_prev;
    bit [31:0]   next_t0, prev_t0;
    bit          next_fired, prev_fired;
    bit [7:0]    mem_idx;
    bit          mem_valid;
    bit [7:0]    held_idx;
    bit          held_valid;
    tbms_pkg::out_word_t pending_results[$];
    int          errors;

    function new();
      item_count  = tbms_pkg::ITEM_COUNT_RST;
      hold_ms     = tbms_pkg::HOLD_TIME_RST;
      settle_ms   = tbms_pkg::SETTLE_TIME_RST;
      active      = 0;
      closing     = 0;
      armed       = 0;
      phase_start = '0;
      cur_idx     = '0;
      checked_idx = tbms_pkg::NO_CHOICE;
      last_next   = 0;
      last_prev   = 0;
      next_t0     = '0;
      prev_t0     = '0;
      next_fired  = 0;
      prev_fired  = 0;
      mem_idx     = '0;
      mem_valid   = 0;
      held_idx    = '0;
      held_valid  = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        tbms_pkg::REG_ITEM_COUNT:  item_count = val[7:0];
        tbms_pkg::REG_HOLD_TIME:   hold_ms = val;
        tbms_pkg::REG_SETTLE_TIME: settle_ms = val;
        default: ;
      endcase
    endfunction

    function void take_word(tbms_pkg::in_word_t w);
      bit [31:0] t_now, settle, hold;
      bit [7:0]  cnt, start;
      bit        chosen, cancel, moved, stop;
      tbms_pkg::out_word_t r;
      t_now  = w.now_ms;
      cnt    = item_count;
      settle = (settle_ms == 16'd0) ? 32'd1 : {16'd0, settle_ms};
      hold   = {16'd0, hold_ms};
      chosen = 0;
      cancel = 0;
      moved  = 0;
      stop   = 0;
      if (active && closing && (t_now - phase_start >= settle)) begin
        active  = 0;
        closing = 0;
      end
      if (w.command == tbms_pkg::CMD_OPEN) begin
        if (cnt != 8'd0 && !(active && !closing)) begin
          next_t0     = '0;
          prev_t0     = '0;
          next_fired  = 0;
          prev_fired  = 0;
          last_next   = 0;
          last_prev   = 0;
          checked_idx = tbms_pkg::NO_CHOICE;
          if (mem_valid && mem_idx < cnt) checked_idx = mem_idx;
          start = w.start_index;
          if (start == tbms_pkg::NO_CHOICE)
            start = (checked_idx < cnt) ? checked_idx : 8'd0;
          else if (start >= cnt) start = 8'd0;
          cur_idx     = start;
          held_idx    = '0;
          held_valid  = 0;
          armed       = 0;
          phase_start = t_now;
          active      = 1;
          closing     = 0;
        end
      end else if (active && !closing && cnt != 8'd0) begin
        if (!armed) begin
          if (t_now - phase_start < settle || w.next_down || w.prev_down) begin
            last_next = w.next_down;
            last_prev = w.prev_down;
          end else begin
            armed     = 1;
            last_next = 0;
            last_prev = 0;
          end
        end else begin
          if (w.next_down) begin
            if (!last_next) begin
              next_t0    = t_now;
              next_fired = 0;
            end else if (!next_fired && next_t0 != 32'd0 && t_now - next_t0 >= hold) begin
              mem_idx     = cur_idx;
              mem_valid   = 1;
              checked_idx = cur_idx;
              held_idx    = cur_idx;
              held_valid  = 1;
              closing     = 1;
              phase_start = t_now;
              next_fired  = 1;
              chosen      = 1;
              stop        = 1;
            end
          end else begin
            if (last_next && !next_fired) begin
              cur_idx = (int'(cur_idx) + 1 < int'(cnt)) ? cur_idx + 8'd1 : 8'd0;
              moved   = 1;
            end
            next_t0    = '0;
            next_fired = 0;
          end
          if (!stop) begin
            if (w.prev_down) begin
              if (!last_prev) begin
                prev_t0    = t_now;
                prev_fired = 0;
              end else if (!prev_fired && prev_t0 != 32'd0 && t_now - prev_t0 >= hold) begin
                closing     = 1;
                phase_start = t_now;
                prev_fired  = 1;
                cancel      = 1;
                stop        = 1;
              end
            end else begin
              if (last_prev && !prev_fired) begin
                cur_idx = (cur_idx > 8'd0) ? cur_idx - 8'd1 : cnt - 8'd1;
                moved   = 1;
              end
              prev_t0    = '0;
              prev_fired = 0;
            end
          end
          if (!stop) begin
            last_next = w.next_down;
            last_prev = w.prev_down;
          end
        end
      end
      r.selected_index = cur_idx;
      r.menu_open      = active;
      r.menu_closing   = closing;
      r.chosen_pulse   = chosen;
      r.cancel_pulse   = cancel;
      r.moved_pulse    = moved;
      r.result_index   = held_idx;
      r.result_ready   = held_valid;
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(tbms_pkg::out_word_t got);
      tbms_pkg::out_word_t want;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("selected_index", want.selected_index, got.selected_index);
      check_field("menu_open", want.menu_open, got.menu_open);
      check_field("menu_closing", want.menu_closing, got.menu_closing);
      check_field("chosen_pulse", want.chosen_pulse, got.chosen_pulse);
      check_field("cancel_pulse", want.cancel_pulse, got.cancel_pulse);
      check_field("moved_pulse", want.moved_pulse, got.moved_pulse);
      check_field("result_index", want.result_index, got.result_index);
      check_field("result_ready", want.result_ready, got.result_ready);
    endfunction

    function bit drained();
      return pending_results.size() == 0;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        hold_req;
  logic        hold_off = 1'b0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          words_sent = 0;
  int unsigned cycle_count = 0;
  bit [31:0]   clock_ms = '0;
  bit [7:0]    cur_count = tbms_pkg::ITEM_COUNT_RST;
  bit [15:0]   cur_hold = tbms_pkg::HOLD_TIME_RST;
  bit [15:0]   cur_settle = tbms_pkg::SETTLE_TIME_RST;
  menu_tracker tracker = new();

  tbms_in_if  in_ch();
  tbms_out_if out_ch();

  two_button_menu_selector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL two_button_menu_selector");
      $finish;
    end
  end

  // check result words and draw the next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) tracker.check_word(out_ch.data);
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    do @(posedge clk); while (!hold_req);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic send_word(tbms_pkg::in_word_t w);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_word(w);
    words_sent++;
  endtask

  task automatic open_menu(bit [7:0] start);
    tbms_pkg::in_word_t w;
    w.command     = tbms_pkg::CMD_OPEN;
    w.now_ms      = clock_ms;
    w.next_down   = 1'($urandom_range(0, 1));
    w.prev_down   = 1'($urandom_range(0, 1));
    w.start_index = start;
    send_word(w);
  endtask

  task automatic buttons(bit nd, bit pd);
    tbms_pkg::in_word_t w;
    w.command     = tbms_pkg::CMD_SAMPLE;
    w.now_ms      = clock_ms;
    w.next_down   = nd;
    w.prev_down   = pd;
    w.start_index = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (!tracker.drained()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  task automatic set_config(bit [7:0] cnt, bit [15:0] hold, bit [15:0] settle);
    wait_idle();
    write_reg(tbms_pkg::REG_ITEM_COUNT, {8'd0, cnt});
    write_reg(tbms_pkg::REG_HOLD_TIME, hold);
    write_reg(tbms_pkg::REG_SETTLE_TIME, settle);
    cfg_we     <= 1'b0;
    cur_count  = cnt;
    cur_hold   = hold;
    cur_settle = settle;
  endtask

  function automatic bit [31:0] pick_gap(bit [31:0] span);
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return span - 32'd1;
      3:       return span;
      4:       return span + 32'd1;
      8:       return span + $urandom_range(0, span);
      9:       return $urandom_range(0, 3);
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task automatic tap(bit nd, bit pd);
    bit [31:0] short_max;
    short_max = {16'd0, cur_hold} / 2;
    clock_ms += $urandom_range(1, 4);
    buttons(nd, pd);
    repeat ($urandom_range(0, 2)) begin
      clock_ms += $urandom_range(0, short_max);
      buttons(nd, pd);
    end
    clock_ms += $urandom_range(0, short_max);
    buttons(1'b0, 1'b0);
  endtask

  task automatic hold_down(bit nd, bit pd);
    clock_ms += $urandom_range(1, 4);
    buttons(nd, pd);
    clock_ms += pick_gap({16'd0, cur_hold});
    buttons(nd, pd);
    if ($urandom_range(0, 1)) begin
      clock_ms += $urandom_range(0, 3);
      buttons(nd, pd);
    end
  endtask

  task automatic run_menu(int budget);
    int        stop_at, r;
    bit [7:0]  start;
    bit [31:0] settle_span;
    bit        done;
    stop_at     = words_sent + budget;
    settle_span = (cur_settle == 16'd0) ? 32'd1 : {16'd0, cur_settle};
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 50) start = 8'($urandom_range(0, (cur_count == 8'd0) ? 0 : cur_count - 1));
      else if (r < 70) start = tbms_pkg::NO_CHOICE;
      else start = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
      open_menu(start);
      // disarmed window: noise, then a clean release after settling
      repeat ($urandom_range(0, 2)) begin
        clock_ms += pick_gap(settle_span);
        buttons(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      clock_ms += settle_span + $urandom_range(0, 3);
      buttons(1'b0, 1'b0);
      done = 0;
      while (!done && words_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 26) tap(1'b1, 1'b0);
        else if (r < 48) tap(1'b0, 1'b1);
        else if (r < 56) tap(1'b1, 1'b1);
        else if (r < 68) begin
          hold_down(1'b1, 1'b0);
          done = 1;
        end else if (r < 78) begin
          hold_down(1'b0, 1'b1);
          done = 1;
        end else if (r < 90) begin
          clock_ms += pick_gap({16'd0, cur_hold});
          buttons(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (r < 95) open_menu(8'($urandom_range(0, 255)));
        else begin
          clock_ms = $urandom();
          buttons(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      repeat ($urandom_range(0, 2)) begin
        clock_ms += pick_gap(settle_span);
        buttons(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) != 0) clock_ms += settle_span + $urandom_range(0, 2);
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= tbms_pkg::REG_ITEM_COUNT;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    hold_req     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: single entry, choose and reopen while closing
    clock_ms = 32'd5;
    buttons(1'b0, 1'b0);
    open_menu(tbms_pkg::NO_CHOICE);
    clock_ms = 32'd100;
    buttons(1'b1, 1'b1);
    clock_ms = 32'd300;
    buttons(1'b0, 1'b0);
    clock_ms = 32'd310;
    buttons(1'b1, 1'b0);
    clock_ms = 32'd710;
    buttons(1'b1, 1'b0);
    clock_ms = 32'd720;
    open_menu(8'd3);

    // empty menu
    set_config(8'd0, 16'd400, 16'd220);
    open_menu(8'd2);
    buttons(1'b1, 1'b0);

    // zero settle, wrap both ways, open while open, both released together
    set_config(8'd5, 16'd100, 16'd0);
    clock_ms = 32'hFFFF_FFF0;
    buttons(1'b0, 1'b0);
    open_menu(8'd7);
    buttons(1'b1, 1'b1);
    buttons(1'b0, 1'b0);
    buttons(1'b0, 1'b1);
    buttons(1'b0, 1'b0);
    buttons(1'b1, 1'b0);
    buttons(1'b0, 1'b0);
    // press starting at time zero never fires
    clock_ms = 32'd0;
    buttons(1'b1, 1'b0);
    clock_ms = 32'd500;
    buttons(1'b1, 1'b0);
    buttons(1'b0, 1'b0);
    clock_ms = 32'd600;
    buttons(1'b0, 1'b1);
    clock_ms = 32'd700;
    buttons(1'b0, 1'b1);
    clock_ms = 32'd701;
    buttons(1'b0, 1'b0);
    open_menu(8'd3);
    clock_ms = 32'd702;
    buttons(1'b0, 1'b0);
    clock_ms = 32'd703;
    buttons(1'b1, 1'b0);
    clock_ms = 32'd803;
    buttons(1'b1, 1'b0);
    clock_ms = 32'd900;
    open_menu(tbms_pkg::NO_CHOICE);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(8'd7, 16'd40, 16'd20);
        1: set_config(8'd255, 16'd1, 16'd0);
        2: set_config(8'd1, 16'd65535, 16'd65535);
        3: set_config(8'd0, 16'd300, 16'd100);
        4: set_config(8'd3, 16'd10, 16'd5);
        default: set_config(8'($urandom_range(1, 16)), 16'($urandom_range(1, 2000)),
                            16'($urandom_range(0, 500)));
      endcase
      src_idle_pct  = (ph % 4 == 1) ? 71 : (ph % 4 == 3) ? 31 : 0;
      snk_stall_pct <= (ph % 4 == 2) ? 71 : (ph % 4 == 3) ? 31 : 0;
      if (ph == 4) hold_req <= 1'b1;
      run_menu((ph == 3) ? 20 : 262);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("PASS two_button_menu_selector");
    end else begin
      $display("FAIL two_button_menu_selector");
    end
    $finish;
  end

endmodule
